// ===== src/link_bringup_state_sequencer_defines.svh =====
// Assertion macros shared by the sequencer RTL.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef LINK_BRINGUP_STATE_SEQUENCER_DEFINES_SVH
`define LINK_BRINGUP_STATE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBSS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");

// Next-cycle implication, checked outside reset.
`define LBSS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequencer assertion failed");

`endif

// ===== src/lbss_pkg.sv =====
`timescale 1ns / 1ps
package lbss_pkg;

	localparam int CFG_W = 24;
	localparam int STATE_W = 4;
	localparam int EVENT_W = 4;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int TIMER_BITS_DEF = 24;

	localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FORCE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WIFI_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DHCP_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UDP_TIMEOUT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PING_TIMEOUT = 2'd3;

	localparam logic [CFG_W-1:0] WIFI_TIMEOUT_RST = 24'd10000;
	localparam logic [CFG_W-1:0] DHCP_TIMEOUT_RST = 24'd10000;
	localparam logic [CFG_W-1:0] UDP_TIMEOUT_RST = 24'd5000;
	localparam logic [CFG_W-1:0] PING_TIMEOUT_RST = 24'd30000;

	localparam logic [STATE_W-1:0] ST_INIT = 4'd0;
	localparam logic [STATE_W-1:0] ST_WIFI_CONNECTING = 4'd1;
	localparam logic [STATE_W-1:0] ST_DHCP_REQUESTING = 4'd2;
	localparam logic [STATE_W-1:0] ST_UDP_STARTING = 4'd4;
	localparam logic [STATE_W-1:0] ST_OPERATIONAL = 4'd6;
	localparam logic [STATE_W-1:0] NUM_STATES = 4'd12;

	localparam logic [EVENT_W-1:0] EV_RECOVERY = 4'd14;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [EVENT_W-1:0] event_code;
		logic [STATE_W-1:0] forced_state;
	} lbss_in_t;

	typedef struct packed {
		logic [STATE_W-1:0] new_state;
		logic [STATE_W-1:0] prior_state;
		logic is_operational;
		logic transitioned;
		logic timed_out;
	} lbss_out_t;

	typedef struct packed {
		logic [CFG_W-1:0] wifi_timeout_ticks;
		logic [CFG_W-1:0] dhcp_timeout_ticks;
		logic [CFG_W-1:0] udp_timeout_ticks;
		logic [CFG_W-1:0] ping_timeout_ticks;
	} lbss_cfg_t;

	localparam logic [0:11][0:15][STATE_W-1:0] NEXT_TABLE = '{
		'{4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		  4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
		'{4'd1, 4'd1, 4'd2, 4'd8, 4'd8, 4'd1, 4'd1, 4'd1,
		  4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd2, 4'd2, 4'd2, 4'd8, 4'd2, 4'd3, 4'd9, 4'd2,
		  4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2},
		'{4'd3, 4'd3, 4'd3, 4'd8, 4'd3, 4'd3, 4'd3, 4'd4,
		  4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
		'{4'd4, 4'd4, 4'd4, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4,
		  4'd4, 4'd5, 4'd10, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4},
		'{4'd5, 4'd5, 4'd5, 4'd8, 4'd5, 4'd5, 4'd5, 4'd5,
		  4'd5, 4'd5, 4'd10, 4'd6, 4'd6, 4'd7, 4'd5, 4'd5},
		'{4'd6, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6, 4'd6,
		  4'd6, 4'd6, 4'd10, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6},
		'{4'd7, 4'd7, 4'd7, 4'd8, 4'd7, 4'd7, 4'd7, 4'd7,
		  4'd7, 4'd7, 4'd10, 4'd5, 4'd6, 4'd7, 4'd11, 4'd11},
		'{4'd8, 4'd1, 4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
		  4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd11, 4'd11},
		'{4'd9, 4'd9, 4'd9, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9,
		  4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd11, 4'd11},
		'{4'd10, 4'd10, 4'd10, 4'd8, 4'd10, 4'd10, 4'd10, 4'd10,
		  4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd11, 4'd11},
		'{4'd11, 4'd1, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
		  4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11}
	};

	function automatic logic [STATE_W-1:0] lbss_next_state(
		input logic [STATE_W-1:0] st,
		input logic [EVENT_W-1:0] ev
	);
		return NEXT_TABLE[st][ev];
	endfunction

endpackage

// ===== src/link_bringup_state_sequencer.sv =====
`timescale 1ns / 1ps
// Link bring-up sequencer with a command channel in and a result channel out.
// Each command transaction carries an event, a time tick or a forced state,
// and produces exactly one result transaction with the new state, the state
// before the last change, the operational flag and the transition and
// timeout marks. Timeout lengths are set through the write-only register
// port and are picked up when a timer is next loaded; write them only while
// no transaction is in flight.
// A command is registered on acceptance and resolved against the sequencer
// state when the input register advances, which loads the result register;
// the result register then offers the result. One command is taken per
// cycle unless cmd_stall holds it off: the state and timer update is
// computed combinationally from the registered state.
// When the receiver stalls, the result register holds its transaction and
// the input register keeps one more; cmd_stall rises only when both are full.
// Reset empties both registers, returns the sequencer to the init state
// with no timer running, and restores the default timeout registers.
module link_bringup_state_sequencer #(
	parameter int TIMER_BITS = lbss_pkg::TIMER_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input lbss_pkg::lbss_in_t cmd_item,
	output logic res_valid,
	input logic res_stall,
	output lbss_pkg::lbss_out_t res_item,
	input logic cfg_we,
	input logic [lbss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lbss_pkg::CFG_W-1:0] cfg_data
);
	import lbss_pkg::*;

	`include "link_bringup_state_sequencer_defines.svh"

	lbss_cfg_t cfg;
	lbss_in_t item_s1;
	logic valid_s1;
	lbss_out_t result;
	lbss_out_t res_s2;
	logic valid_s2;
	logic advance;
	logic accept;

	assign advance = valid_s1 && (!valid_s2 || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign accept = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!res_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd_item;
		end
		if (advance) begin
			res_s2 <= result;
		end
	end

	lbss_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	lbss_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.item(item_s1),
		.cfg(cfg),
		.result(result)
	);

	assign res_valid = valid_s2;
	assign res_item = res_s2;

	`LBSS_ASSERT_NOW(a_stall_when_full, valid_s1 && valid_s2 && res_stall, cmd_stall)
	`LBSS_ASSERT_NOW(a_oper_flag, valid_s2 && res_s2.is_operational,
		res_s2.new_state == ST_OPERATIONAL)
	`LBSS_ASSERT_NOW(a_moved_differs, valid_s2 && res_s2.transitioned,
		res_s2.new_state != res_s2.prior_state)
	`LBSS_ASSERT_NEXT(a_advance_fills, advance, valid_s2)

endmodule

// ===== src/lbss_cfg.sv =====
`timescale 1ns / 1ps
module lbss_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lbss_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lbss_pkg::CFG_W-1:0] cfg_data,
	output lbss_pkg::lbss_cfg_t cfg
);
	import lbss_pkg::*;

	lbss_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wifi_timeout_ticks <= WIFI_TIMEOUT_RST;
			cfg_q.dhcp_timeout_ticks <= DHCP_TIMEOUT_RST;
			cfg_q.udp_timeout_ticks <= UDP_TIMEOUT_RST;
			cfg_q.ping_timeout_ticks <= PING_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIFI_TIMEOUT: cfg_q.wifi_timeout_ticks <= cfg_data;
				REG_DHCP_TIMEOUT: cfg_q.dhcp_timeout_ticks <= cfg_data;
				REG_UDP_TIMEOUT: cfg_q.udp_timeout_ticks <= cfg_data;
				REG_PING_TIMEOUT: cfg_q.ping_timeout_ticks <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/lbss_core.sv =====
`timescale 1ns / 1ps
module lbss_core #(
	parameter int TIMER_BITS = lbss_pkg::TIMER_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic step,
	input lbss_pkg::lbss_in_t item,
	input lbss_pkg::lbss_cfg_t cfg,
	output lbss_pkg::lbss_out_t result
);
	import lbss_pkg::*;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] before_q;
	logic oper_q;
	logic [TIMER_BITS-1:0] remain_q;
	logic running_q;

	logic [EVENT_W-1:0] ev_sel;
	logic [STATE_W-1:0] table_next;
	logic [STATE_W-1:0] target;
	logic request;
	logic expire;
	logic moved;
	logic [CFG_W-1:0] sel_cfg;
	logic [TIMER_BITS-1:0] load_val;

	logic [STATE_W-1:0] state_d;
	logic [STATE_W-1:0] before_d;
	logic oper_d;
	logic [TIMER_BITS-1:0] remain_d;
	logic running_d;

	assign ev_sel = (item.command == CMD_TICK) ? EV_RECOVERY : item.event_code;
	assign table_next = lbss_next_state(state_q, ev_sel);
	assign expire = (item.command == CMD_TICK) && running_q
		&& (remain_q[TIMER_BITS-1:1] == '0);

	always_comb begin
		request = 1'b0;
		target = table_next;
		unique case (item.command)
			CMD_EVENT: request = 1'b1;
			CMD_TICK: request = expire;
			CMD_FORCE: begin
				request = (item.forced_state < NUM_STATES);
				target = item.forced_state;
			end
			default: request = 1'b0;
		endcase
	end

	assign moved = request && (target != state_q);

	always_comb begin
		case (target)
			ST_WIFI_CONNECTING: sel_cfg = cfg.wifi_timeout_ticks;
			ST_DHCP_REQUESTING: sel_cfg = cfg.dhcp_timeout_ticks;
			ST_UDP_STARTING: sel_cfg = cfg.udp_timeout_ticks;
			ST_OPERATIONAL: sel_cfg = cfg.ping_timeout_ticks;
			default: sel_cfg = '0;
		endcase
	end

	generate
		if (TIMER_BITS >= CFG_W) begin : g_wide_timer
			assign load_val = TIMER_BITS'(sel_cfg);
		end else begin : g_narrow_timer
			assign load_val = (|sel_cfg[CFG_W-1:TIMER_BITS]) ? '1
				: sel_cfg[TIMER_BITS-1:0];
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		before_d = before_q;
		oper_d = oper_q;
		remain_d = remain_q;
		running_d = running_q;
		if ((item.command == CMD_TICK) && running_q) begin
			if (expire) begin
				remain_d = '0;
				running_d = 1'b0;
			end else begin
				remain_d = remain_q - TIMER_BITS'(1);
			end
		end
		if (moved) begin
			before_d = state_q;
			state_d = target;
			oper_d = (target == ST_OPERATIONAL);
			remain_d = load_val;
			running_d = (load_val != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			before_q <= ST_INIT;
			oper_q <= 1'b0;
			remain_q <= '0;
			running_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			before_q <= before_d;
			oper_q <= oper_d;
			remain_q <= remain_d;
			running_q <= running_d;
		end
	end

	assign result.new_state = state_d;
	assign result.prior_state = before_d;
	assign result.is_operational = oper_d;
	assign result.transitioned = moved;
	assign result.timed_out = expire;

endmodule
